@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files that check their own logic; the top level uses them.
// No dependencies; take in with `include before the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted (active low)
`define PDLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off while reset is asserted (active low)
`define PDLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pdle_pkg.sv @@
// Shared codes and types of the positional deque list engine.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pdle_pkg;

    // Request kinds
    localparam logic [2:0] K_PUSH_FRONT = 3'd0;
    localparam logic [2:0] K_PUSH_BACK  = 3'd1;
    localparam logic [2:0] K_POP_FRONT  = 3'd2;
    localparam logic [2:0] K_POP_BACK   = 3'd3;
    localparam logic [2:0] K_INSERT     = 3'd4;
    localparam logic [2:0] K_GET        = 3'd5;
    localparam logic [2:0] K_REMOVE     = 3'd6;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Datapath micro-operations
    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_DECIDE     = 4'd1;
    localparam logic [3:0] OP_ALLOC_RD   = 4'd2;
    localparam logic [3:0] OP_ALLOC_WR   = 4'd3;
    localparam logic [3:0] OP_LINK       = 4'd4;
    localparam logic [3:0] OP_WALK_START = 4'd5;
    localparam logic [3:0] OP_WALK       = 4'd6;
    localparam logic [3:0] OP_NODE_RD    = 4'd7;
    localparam logic [3:0] OP_USE        = 4'd8;
    localparam logic [3:0] OP_INS_LINK   = 4'd9;
    localparam logic [3:0] OP_FINISH     = 4'd10;

    // Controller to datapath
    typedef struct packed {
        logic       load;    // request beat accepted this cycle
        logic [3:0] op;      // micro-operation
        logic [1:0] status;  // status of the current request
    } pdle_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] kind;
        logic       full;
        logic       empty;
        logic       oob;       // position at or past the entry count
        logic       pos_zero;
        logic       cnt_zero;  // walk has reached its node
        logic       out_free;  // result register can take a new beat
    } pdle_sts_t;

endpackage

@@ hw/rtl/pdle_ctrl.sv @@
// Sequencer of the positional deque list engine.
// Depends on pdle_pkg; drives the datapath through pdle_cmd_t.
`timescale 1ns / 1ps

module pdle_ctrl
    import pdle_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pdle_sts_t sts,
    output pdle_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_DECIDE     = 4'd1;
    localparam logic [3:0] ST_ALLOC_RD   = 4'd2;
    localparam logic [3:0] ST_ALLOC_WR   = 4'd3;
    localparam logic [3:0] ST_LINK       = 4'd4;
    localparam logic [3:0] ST_WALK_START = 4'd5;
    localparam logic [3:0] ST_WALK       = 4'd6;
    localparam logic [3:0] ST_NODE_RD    = 4'd7;
    localparam logic [3:0] ST_USE        = 4'd8;
    localparam logic [3:0] ST_INS_LINK   = 4'd9;
    localparam logic [3:0] ST_FINISH     = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and request status
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next  = ST_DECIDE;
                    status_next = STAT_OK;
                end
            end
            ST_DECIDE: begin
                unique case (sts.kind)
                    K_PUSH_FRONT, K_PUSH_BACK: begin
                        if (sts.full) begin
                            status_next = STAT_FULL;
                            state_next  = ST_FINISH;
                        end else begin
                            state_next = ST_ALLOC_RD;
                        end
                    end
                    K_POP_FRONT, K_POP_BACK: begin
                        if (sts.empty) begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_FINISH;
                        end else begin
                            state_next = ST_NODE_RD;
                        end
                    end
                    K_INSERT: begin
                        priority if (sts.oob) begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_FINISH;
                        end else if (sts.full) begin
                            status_next = STAT_FULL;
                            state_next  = ST_FINISH;
                        end else begin
                            state_next = ST_WALK_START;
                        end
                    end
                    K_GET, K_REMOVE: begin
                        if (sts.oob) begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_FINISH;
                        end else begin
                            state_next = ST_WALK_START;
                        end
                    end
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_WALK_START: state_next = sts.pos_zero ? ST_NODE_RD : ST_WALK;
            ST_WALK:       state_next = sts.cnt_zero ? ST_NODE_RD : ST_WALK;
            ST_NODE_RD:    state_next = ST_USE;
            ST_USE:        state_next = (sts.kind == K_INSERT) ? ST_ALLOC_RD : ST_FINISH;
            ST_ALLOC_RD:   state_next = ST_ALLOC_WR;
            ST_ALLOC_WR:   state_next = (sts.kind == K_INSERT) ? ST_INS_LINK : ST_LINK;
            ST_LINK:       state_next = ST_FINISH;
            ST_INS_LINK:   state_next = ST_FINISH;
            ST_FINISH:     state_next = sts.out_free ? ST_IDLE : ST_FINISH;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            status_reg <= STAT_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // Command to the datapath
    always_comb begin
        cmd.load   = s_tvalid && s_tready;
        cmd.status = status_reg;
        unique case (state_reg)
            ST_DECIDE:     cmd.op = OP_DECIDE;
            ST_ALLOC_RD:   cmd.op = OP_ALLOC_RD;
            ST_ALLOC_WR:   cmd.op = OP_ALLOC_WR;
            ST_LINK:       cmd.op = OP_LINK;
            ST_WALK_START: cmd.op = OP_WALK_START;
            ST_WALK:       cmd.op = OP_WALK;
            ST_NODE_RD:    cmd.op = OP_NODE_RD;
            ST_USE:        cmd.op = OP_USE;
            ST_INS_LINK:   cmd.op = OP_INS_LINK;
            ST_FINISH:     cmd.op = OP_FINISH;
            default:       cmd.op = OP_NONE;
        endcase
    end

endmodule

@@ hw/rtl/pdle_dpath.sv @@
// Datapath of the positional deque list engine: node memories, free stack,
// list registers and the result register. Depends on pdle_pkg.
`timescale 1ns / 1ps

module pdle_dpath
    import pdle_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  pdle_cmd_t        cmd,
    output pdle_sts_t        sts,
    input  logic [2:0]       req_kind,
    input  logic [7:0]       req_position,
    input  logic [31:0]      req_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_read_value,
    output logic [1:0]       m_status,
    output logic [8:0]       m_entries,
    output logic             m_is_empty
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    // Node storage and free stack
    logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
    logic [IW-1:0]          next_mem  [CAPACITY];
    logic [IW-1:0]          prev_mem  [CAPACITY];
    logic [IW-1:0]          fs_mem    [CAPACITY];
    logic [VALUE_WIDTH-1:0] value_rd;
    logic [IW-1:0]          next_rd, prev_rd, fs_rd;

    // Request and work registers
    logic [2:0]    kind_reg;
    logic [7:0]    pos_reg, cnt_reg, cnt_next;
    logic [31:0]   val_reg;
    logic [IW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [IW-1:0] t_reg, t_next, n_reg, pv_reg, idx_reg;
    logic [CW-1:0] count_reg, count_next, top_reg, top_next, wm_reg, wm_next;
    logic          fresh_reg;
    logic [31:0]   rd_reg, rd_next;
    logic [31:0]   out_value_reg;
    logic [1:0]    out_status_reg;
    logic [8:0]    out_entries_reg;
    logic          out_empty_reg, valid_reg;

    logic          is_front, is_back, is_pop, is_unlink, has_items;
    logic [IW-1:0] n_comb, alloc_idx;
    logic          out_free;
    logic [63:0]   value_ext;

    // Memory port controls
    logic                   value_we, next_we, prev_we, fs_we;
    logic [IW-1:0]          value_wa, next_wa, prev_wa, fs_wa;
    logic [VALUE_WIDTH-1:0] value_wd;
    logic [IW-1:0]          next_wd, prev_wd, fs_wd;
    logic [IW-1:0]          next_ra, fs_ra;

    assign is_front  = (kind_reg == K_PUSH_FRONT);
    assign is_back   = (kind_reg == K_PUSH_BACK);
    assign is_pop    = (kind_reg == K_POP_FRONT) || (kind_reg == K_POP_BACK);
    assign is_unlink = is_pop || (kind_reg == K_REMOVE);
    assign has_items = (count_reg != '0);
    assign alloc_idx = IW'(top_reg - CW'(1));
    assign n_comb    = fresh_reg ? idx_reg : fs_rd;
    assign out_free  = !valid_reg || m_ready;
    assign value_ext = 64'($signed(value_rd));

    // Status toward the controller
    always_comb begin
        sts.kind     = kind_reg;
        sts.full     = (count_reg == CW'(CAPACITY)) || (top_reg == '0);
        sts.empty    = !has_items;
        sts.oob      = PW'(pos_reg) >= PW'(count_reg);
        sts.pos_zero = (pos_reg == '0);
        sts.cnt_zero = (cnt_reg == '0);
        sts.out_free = out_free;
    end

    // Memory writes and register updates for each micro-operation
    always_comb begin
        value_we = 1'b0; value_wa = n_comb; value_wd = VALUE_WIDTH'(val_reg);
        next_we  = 1'b0; next_wa  = n_comb; next_wd  = '0;
        prev_we  = 1'b0; prev_wa  = n_comb; prev_wd  = '0;
        fs_we    = 1'b0; fs_wa    = IW'(top_reg); fs_wd = t_reg;
        next_ra  = t_reg;
        fs_ra    = alloc_idx;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        top_next   = top_reg;
        wm_next    = wm_reg;
        t_next     = t_reg;
        cnt_next   = cnt_reg;
        rd_next    = rd_reg;
        unique case (cmd.op)
            OP_DECIDE: begin
                t_next = (kind_reg == K_POP_BACK) ? tail_reg : head_reg;
            end
            OP_WALK_START: begin
                t_next   = head_reg;
                next_ra  = head_reg;
                cnt_next = pos_reg - 8'd1;
            end
            OP_WALK: begin
                next_ra = next_rd;
                if (cnt_reg == '0) begin
                    t_next = next_rd;
                end else begin
                    cnt_next = cnt_reg - 8'd1;
                end
            end
            OP_USE: begin
                if (is_pop || (kind_reg == K_GET)) begin
                    rd_next = value_ext[31:0];
                end
                if (is_unlink) begin
                    if (count_reg == CW'(1)) begin
                        head_next = '0;
                        tail_next = '0;
                    end else begin
                        if (t_reg == head_reg) begin
                            head_next = next_rd;
                        end else begin
                            next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
                        end
                        if (t_reg == tail_reg) begin
                            tail_next = prev_rd;
                        end else begin
                            prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
                        end
                    end
                    count_next = count_reg - CW'(1);
                    if (top_reg < CW'(CAPACITY)) begin
                        fs_we    = 1'b1;
                        top_next = top_reg + CW'(1);
                    end
                end
            end
            OP_ALLOC_RD: begin
                top_next = top_reg - CW'(1);
                if (top_reg == wm_reg) begin
                    wm_next = top_reg - CW'(1);
                end
            end
            OP_ALLOC_WR: begin
                value_we = 1'b1;
                next_we  = 1'b1;
                prev_we  = 1'b1;
                priority if (kind_reg == K_INSERT) begin
                    next_wd = t_reg;
                    prev_wd = pv_reg;
                end else if (has_items && is_front) begin
                    next_wd = head_reg;
                end else if (has_items && is_back) begin
                    prev_wd = tail_reg;
                end else begin
                    next_wd = '0;
                end
            end
            OP_LINK: begin
                if (!has_items) begin
                    head_next = n_reg;
                    tail_next = n_reg;
                end else if (is_front) begin
                    prev_we = 1'b1; prev_wa = head_reg; prev_wd = n_reg;
                    head_next = n_reg;
                end else begin
                    next_we = 1'b1; next_wa = tail_reg; next_wd = n_reg;
                    tail_next = n_reg;
                end
                count_next = count_reg + CW'(1);
            end
            OP_INS_LINK: begin
                if (t_reg == head_reg) begin
                    head_next = n_reg;
                end else begin
                    next_we = 1'b1; next_wa = pv_reg; next_wd = n_reg;
                end
                prev_we = 1'b1; prev_wa = t_reg; prev_wd = n_reg;
                count_next = count_reg + CW'(1);
            end
            default: begin
            end
        endcase
    end

    // Node memories, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (value_we) begin
            value_mem[value_wa] <= value_wd;
        end
        value_rd <= value_mem[t_reg];
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd <= next_mem[next_ra];
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_rd <= prev_mem[t_reg];
    end

    // Free stack; for slots below the low-water mark the slot's own index is used, not the memory
    always_ff @(posedge aclk) begin
        if (fs_we) begin
            fs_mem[fs_wa] <= fs_wd;
        end
        fs_rd <= fs_mem[fs_ra];
    end

    // List control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            top_reg   <= CW'(CAPACITY);
            wm_reg    <= CW'(CAPACITY);
            valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            top_reg   <= top_next;
            wm_reg    <= wm_next;
            if (cmd.op == OP_FINISH && out_free) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Request, walk and result payload
    always_ff @(posedge aclk) begin
        t_reg   <= t_next;
        cnt_reg <= cnt_next;
        rd_reg  <= rd_next;
        if (cmd.load) begin
            kind_reg <= req_kind;
            pos_reg  <= req_position;
            val_reg  <= req_value;
            rd_reg   <= '0;
        end
        if (cmd.op == OP_USE) begin
            pv_reg <= prev_rd;
        end
        if (cmd.op == OP_ALLOC_RD) begin
            fresh_reg <= (top_reg == wm_reg);
            idx_reg   <= alloc_idx;
        end
        if (cmd.op == OP_ALLOC_WR) begin
            n_reg <= n_comb;
        end
        if (cmd.op == OP_FINISH && out_free) begin
            out_value_reg   <= rd_reg;
            out_status_reg  <= cmd.status;
            out_entries_reg <= 9'(count_reg);
            out_empty_reg   <= !has_items;
        end
    end

    assign m_valid      = valid_reg;
    assign m_read_value = out_value_reg;
    assign m_status     = out_status_reg;
    assign m_entries    = out_entries_reg;
    assign m_is_empty   = out_empty_reg;

endmodule

@@ hw/rtl/positional_deque_list_engine_core.sv @@
// Request beat to result valid: a push or pop goes straight to its list update, while get,
// remove and insert first walk the links from the head, one next-link read per cycle. A
// result waits in the output register until m_tready, and finish holds until it is free.
// Requests are taken one at a time; the request side reopens when the result loads.
// Reset: synchronous, active low; list empties and all nodes return free at once.
// Top level of the positional deque list engine. Depends on pdle_pkg,
// pdle_ctrl, pdle_dpath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module positional_deque_list_engine_core
    import pdle_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[7:0], value[39:8]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_value[31:0], entries[40:32], is_empty[41]
    output logic [1:0]  m_tuser    // status[1:0]
);

    pdle_cmd_t   cmd;
    pdle_sts_t   sts;
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [8:0]  entries;
    logic        is_empty;

    pdle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdle_dpath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .req_kind     (s_tuser),
        .req_position (s_tdata[7:0]),
        .req_value    (s_tdata[39:8]),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_read_value (read_value),
        .m_status     (status),
        .m_entries    (entries),
        .m_is_empty   (is_empty)
    );

    assign m_tdata = {6'd0, is_empty, entries, read_value};
    assign m_tuser = status;

    // A refused push or insert only happens with every node in use
    `PDLE_ASSERT_IMPL(a_full_at_capacity, aclk, aresetn, m_tvalid && status == STAT_FULL, entries == 9'(CAPACITY), "full status below capacity")
    // Empty flag goes with a zero entry count
    `PDLE_ASSERT_IMPL(a_empty_count, aclk, aresetn, m_tvalid && is_empty, entries == 9'd0, "empty flag with entries held")
    // Request side closes for the cycle after a beat is taken
    `PDLE_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")
    // Finish only moves on when the result register is free
    `PDLE_ASSERT_NEXT(a_finish_loads, aclk, aresetn, cmd.op == OP_FINISH && sts.out_free, m_tvalid, "result lost at finish")

endmodule
